// ----- hw/rtl/prc_pkg.sv -----
// ---------------------------------------------------------------------------
// prc_pkg
// shared constants, types and tables of the polar/rectangular converter
// ---------------------------------------------------------------------------
package prc_pkg;

  localparam int CORDIC_STEPS  = 16;
  localparam int FRACTION_BITS = 16;
  localparam int GUARD_BITS    = 16;
  localparam int TABLE_LEN     = 30;

  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;
  localparam int PRE_SHIFT = 32 - GUARD_BITS;
  localparam int ANG_SHIFT = 32 - FRACTION_BITS;

  localparam logic KIND_RECT  = 1'b0;
  localparam logic KIND_POLAR = 1'b1;

  // widths
  localparam int OP_W = 33;             // operand after left-half swap
  localparam int PS_W = 50;             // prescaled operand
  localparam int DW   = 52;             // cordic x/y datapath
  localparam int ZW   = 34;             // binary angle, 2^32 per turn

  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sh40000000);
  localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(64'sh80000000);

  // angle degrees to turns: floor((b*2^(ANG_SHIFT-3) + 22) / 45), radix-256 digits
  localparam int DIV_DIGITS = (ANG_SHIFT + 32 + 7) / 8;
  localparam int DIV_W      = 8 * DIV_DIGITS;
  localparam logic [DIV_W-1:0] DIV_OFFSET = DIV_W'(45) << (ANG_SHIFT + 24);
  localparam logic [DIV_W-1:0] DIV_ROUND  = DIV_W'(22);
  localparam logic [14:0] RECIP_45 = 15'd23302;
  localparam int RECIP_SHIFT = 20;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                     kind;
    logic                     zero;
    logic signed [OP_W-1:0]   pa;
    logic signed [OP_W-1:0]   pb;
    logic signed [ZW-1:0]     zr;
    logic [DIV_W-1:0]         ppos;
    logic [5:0]               rem;
    logic [31:0]              quot;
    logic signed [PS_W-1:0]   pa_hi;
    logic signed [PS_W-1:0]   pa_lo;
    logic signed [PS_W-1:0]   pb_hi;
    logic signed [PS_W-1:0]   pb_lo;
    logic signed [PS_W-1:0]   xs;
    logic signed [PS_W-1:0]   ys;
  } front_t;

  typedef struct packed {
    logic                     kind;
    logic                     zero;
    logic signed [PS_W-1:0]   xs;
    logic signed [PS_W-1:0]   ys;
    logic signed [ZW-1:0]     z;
  } queue_t;

  typedef struct packed {
    logic                     kind;
    logic                     zero;
    logic signed [DW-1:0]     x;
    logic signed [DW-1:0]     y;
    logic signed [ZW-1:0]     z;
  } back_t;

  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
      27: v = 32'h00000005;  28: v = 32'h00000003;  29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/prc_in_if.sv -----
// ---------------------------------------------------------------------------
// prc_in_if
// request channel: conversion kind and two operands
// ---------------------------------------------------------------------------
interface prc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] first_value;
  logic [31:0] second_value;

  modport source (output valid, kind, first_value, second_value, input ready);
  modport sink   (input valid, kind, first_value, second_value, output ready);
endinterface

// ----- hw/rtl/prc_out_if.sv -----
// ---------------------------------------------------------------------------
// prc_out_if
// result channel: two results and the saturation flag
// ---------------------------------------------------------------------------
interface prc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_result;
  logic [31:0] second_result;
  logic        saturated;

  modport source (output valid, first_result, second_result, saturated, input ready);
  modport sink   (input valid, first_result, second_result, saturated, output ready);
endinterface

// ----- hw/rtl/prc_front.sv -----
// ---------------------------------------------------------------------------
// prc_front
// classifies requests, folds the left half plane, prescales by the cordic
// gain and turns input degrees into binary angle
// ---------------------------------------------------------------------------
module prc_front (
  input  logic            clk,
  input  logic            rst,
  prc_in_if.sink          req,
  input  logic            full,
  output logic            push,
  output prc_pkg::queue_t push_data
);

  localparam int NF = prc_pkg::DIV_DIGITS + 1;

  prc_pkg::front_t fs [NF];
  logic [NF-1:0]   fv;
  logic            en;
  prc_pkg::front_t f0;

  assign en        = !fv[NF-1] || !full;
  assign req.ready = en;
  assign push      = fv[NF-1] && !full;

  // operand stage
  always_comb begin
    logic signed [prc_pkg::OP_W-1:0]  a_e;
    logic signed [prc_pkg::OP_W-1:0]  b_e;
    logic signed [prc_pkg::DIV_W-1:0] bw;
    a_e = {req.first_value[31], req.first_value};
    b_e = {req.second_value[31], req.second_value};
    bw  = {{(prc_pkg::DIV_W-32){req.second_value[31]}}, req.second_value};
    f0      = '0;
    f0.kind = req.kind;
    f0.zero = (req.first_value == 32'd0) && (req.second_value == 32'd0);
    f0.pa   = a_e;
    f0.pb   = b_e;
    f0.zr   = '0;
    if (req.kind == prc_pkg::KIND_RECT && a_e < 0) begin
      if (b_e >= 0) begin
        f0.pa = b_e;
        f0.pb = -a_e;
        f0.zr = prc_pkg::QUARTER_TURN;
      end else begin
        f0.pa = -b_e;
        f0.pb = a_e;
        f0.zr = -prc_pkg::QUARTER_TURN;
      end
    end
    // offset keeps the dividend positive; it only moves quotient bits above 31
    f0.ppos = (bw <<< (prc_pkg::ANG_SHIFT - 3)) + prc_pkg::DIV_ROUND + prc_pkg::DIV_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv[0] <= 1'b0;
    end else if (en) begin
      fv[0] <= req.valid;
    end
    if (en) begin
      fs[0] <= f0;
    end
  end

  for (genvar k = 1; k < NF; k++) begin : g_stage
    prc_pkg::front_t nxt;

    always_comb begin
      logic [13:0] val;
      logic [28:0] prod;
      logic [7:0]  qd;
      logic signed [prc_pkg::PS_W-1:0] ghi;
      logic signed [prc_pkg::PS_W-1:0] glo;
      logic signed [prc_pkg::PS_W-1:0] rnd;
      nxt  = fs[k-1];
      val  = {fs[k-1].rem, fs[k-1].ppos[prc_pkg::DIV_W-1-8*(k-1) -: 8]};
      prod = 29'(val) * 29'(prc_pkg::RECIP_45);
      qd   = prod[prc_pkg::RECIP_SHIFT +: 8];
      nxt.rem  = 6'(val - 14'(qd) * 14'd45);
      nxt.quot = {fs[k-1].quot[23:0], qd};
      ghi = $signed({{(prc_pkg::PS_W-prc_pkg::GUARD_BITS){1'b0}},
                     prc_pkg::GAIN_Q32[31:prc_pkg::PRE_SHIFT]});
      glo = $signed({{(prc_pkg::PS_W-prc_pkg::PRE_SHIFT){1'b0}},
                     prc_pkg::GAIN_Q32[prc_pkg::PRE_SHIFT-1:0]});
      rnd = prc_pkg::PS_W'(1) <<< (prc_pkg::PRE_SHIFT - 1);
      if (k == 1) begin
        nxt.pa_hi = prc_pkg::PS_W'(fs[k-1].pa) * ghi;
        nxt.pa_lo = prc_pkg::PS_W'(fs[k-1].pa) * glo;
        nxt.pb_hi = prc_pkg::PS_W'(fs[k-1].pb) * ghi;
        nxt.pb_lo = prc_pkg::PS_W'(fs[k-1].pb) * glo;
      end
      if (k == 2) begin
        nxt.xs = fs[k-1].pa_hi + ((fs[k-1].pa_lo + rnd) >>> prc_pkg::PRE_SHIFT);
        nxt.ys = fs[k-1].pb_hi + ((fs[k-1].pb_lo + rnd) >>> prc_pkg::PRE_SHIFT);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        fv[k] <= 1'b0;
      end else if (en) begin
        fv[k] <= fv[k-1];
      end
      if (en) begin
        fs[k] <= nxt;
      end
    end
  end

  always_comb begin
    push_data.kind = fs[NF-1].kind;
    push_data.zero = fs[NF-1].zero;
    push_data.xs   = fs[NF-1].xs;
    push_data.ys   = fs[NF-1].ys;
    if (fs[NF-1].kind == prc_pkg::KIND_POLAR) begin
      push_data.z = {{(prc_pkg::ZW-32){fs[NF-1].quot[31]}}, fs[NF-1].quot};
    end else begin
      push_data.z = fs[NF-1].zr;
    end
  end

endmodule

// ----- hw/rtl/prc_queue.sv -----
// ---------------------------------------------------------------------------
// prc_queue
// short first-in first-out queue between the front and back parts
// ---------------------------------------------------------------------------
module prc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  prc_pkg::queue_t push_data,
  input  logic            pop,
  output prc_pkg::queue_t head,
  output logic            full,
  output logic            empty
);

  prc_pkg::queue_t                mem [prc_pkg::QUEUE_DEPTH];
  logic [prc_pkg::QPTR_W-1:0]     wptr;
  logic [prc_pkg::QPTR_W-1:0]     rptr;
  logic [prc_pkg::QCNT_W-1:0]     count;

  assign full  = (count == prc_pkg::QCNT_W'(prc_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == prc_pkg::QPTR_W'(prc_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == prc_pkg::QPTR_W'(prc_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/prc_back.sv -----
// ---------------------------------------------------------------------------
// prc_back
// pipelined cordic, one micro-rotation per stage, then rounding,
// saturation and angle scaling into the output register
// ---------------------------------------------------------------------------
module prc_back (
  input  logic            clk,
  input  logic            rst,
  input  prc_pkg::queue_t head,
  input  logic            empty,
  output logic            pop,
  prc_out_if.source       rsp
);

  localparam int NS = prc_pkg::CORDIC_STEPS;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } clip_t;

  prc_pkg::back_t bs [NS+1];
  logic [NS:0]    bv;
  logic           en;
  prc_pkg::back_t b0;

  logic        out_valid;
  logic [31:0] out_first;
  logic [31:0] out_second;
  logic        out_sat;

  assign en  = !out_valid || rsp.ready;
  assign pop = en && !empty;

  assign rsp.valid         = out_valid;
  assign rsp.first_result  = out_first;
  assign rsp.second_result = out_second;
  assign rsp.saturated     = out_sat;

  function automatic clip_t clip(input logic signed [prc_pkg::DW-1:0] v);
    logic signed [prc_pkg::DW-1:0] r;
    clip_t c;
    r = (v + (prc_pkg::DW'(1) <<< (prc_pkg::GUARD_BITS - 1))) >>> prc_pkg::GUARD_BITS;
    c.sat = 1'b1;
    if (r > $signed(prc_pkg::DW'(32'sh7fffffff))) begin
      c.val = 32'h7fffffff;
    end else if (r < $signed(prc_pkg::DW'(-64'sh80000000))) begin
      c.val = 32'h80000000;
    end else begin
      c.val = r[31:0];
      c.sat = 1'b0;
    end
    return c;
  endfunction

  // load stage: polar angles beyond a quarter turn flip the start vector
  always_comb begin
    b0.kind = head.kind;
    b0.zero = head.zero;
    b0.x    = prc_pkg::DW'(head.xs);
    b0.y    = prc_pkg::DW'(head.ys);
    b0.z    = head.z;
    if (head.kind == prc_pkg::KIND_POLAR) begin
      b0.y = '0;
      if (head.z > prc_pkg::QUARTER_TURN) begin
        b0.z = head.z - prc_pkg::HALF_TURN;
        b0.x = -prc_pkg::DW'(head.xs);
      end else if (head.z < -prc_pkg::QUARTER_TURN) begin
        b0.z = head.z + prc_pkg::HALF_TURN;
        b0.x = -prc_pkg::DW'(head.xs);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bv[0] <= 1'b0;
    end else if (en) begin
      bv[0] <= !empty;
    end
    if (en) begin
      bs[0] <= b0;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    prc_pkg::back_t nxt;

    always_comb begin
      logic signed [prc_pkg::DW-1:0] dx;
      logic signed [prc_pkg::DW-1:0] dy;
      logic signed [prc_pkg::ZW-1:0] at;
      logic                          pos;
      dx  = $signed(bs[i].y) >>> i;
      dy  = $signed(bs[i].x) >>> i;
      at  = $signed({2'b00, prc_pkg::atan_turn(i)});
      nxt = bs[i];
      if (bs[i].kind == prc_pkg::KIND_POLAR) begin
        pos = !bs[i].z[prc_pkg::ZW-1];
        if (pos) begin
          nxt.x = bs[i].x - dx;
          nxt.y = bs[i].y + dy;
          nxt.z = bs[i].z - at;
        end else begin
          nxt.x = bs[i].x + dx;
          nxt.y = bs[i].y - dy;
          nxt.z = bs[i].z + at;
        end
      end else begin
        pos = !bs[i].y[prc_pkg::DW-1];
        if (pos) begin
          nxt.x = bs[i].x + dx;
          nxt.y = bs[i].y - dy;
          nxt.z = bs[i].z + at;
        end else begin
          nxt.x = bs[i].x - dx;
          nxt.y = bs[i].y + dy;
          nxt.z = bs[i].z - at;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        bv[i+1] <= 1'b0;
      end else if (en) begin
        bv[i+1] <= bv[i];
      end
      if (en) begin
        bs[i+1] <= nxt;
      end
    end
  end

  // output formatting
  logic [31:0] first_next;
  logic [31:0] second_next;
  logic        sat_next;

  always_comb begin
    clip_t cx;
    clip_t cy;
    logic signed [prc_pkg::ZW-1:0]   zc;
    logic signed [prc_pkg::ZW+8:0]   deg;
    cx  = clip(bs[NS].x);
    cy  = clip(bs[NS].y);
    zc  = bs[NS].z;
    if (zc > prc_pkg::HALF_TURN) begin
      zc = prc_pkg::HALF_TURN;
    end else if (zc < -prc_pkg::HALF_TURN) begin
      zc = -prc_pkg::HALF_TURN;
    end
    deg = (prc_pkg::ZW'(zc) * $signed((prc_pkg::ZW+9)'(360))
           + ((prc_pkg::ZW+9)'(1) <<< (31 - prc_pkg::FRACTION_BITS)))
          >>> (32 - prc_pkg::FRACTION_BITS);
    if (bs[NS].kind == prc_pkg::KIND_POLAR) begin
      first_next  = cx.val;
      second_next = cy.val;
      sat_next    = cx.sat || cy.sat;
    end else if (bs[NS].zero) begin
      first_next  = '0;
      second_next = '0;
      sat_next    = 1'b0;
    end else begin
      first_next  = cx.val;
      second_next = deg[31:0];
      sat_next    = cx.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= bv[NS];
    end
    if (en) begin
      out_first  <= first_next;
      out_second <= second_next;
      out_sat    <= sat_next;
    end
  end

endmodule

// ----- hw/rtl/polar_rect_converter_core.sv -----
// ---------------------------------------------------------------------------
// polar_rect_converter_core
// cordic converter between rectangular and polar coordinates, Q15.16
// ---------------------------------------------------------------------------
// req carries kind (0 rect to polar, 1 polar to rect) and two Q15.16 operands;
// rsp returns magnitude/angle or x/y plus a saturation flag, one result per
// transaction, in request order. angles are degrees, -180..180 on output.
// on its way from the accepting edge to rsp.valid, the transaction passes
// 26 registers, the first loaded at that edge:
// 7 front stages (operand fold, then six radix-256 digits of the degree to
// binary angle division, with the gain prescale in the first two of them),
// one queue slot, a load stage, 16 cordic stages and the output register.
// throughput is one transaction per cycle; the front and the cordic pipeline
// each advance as a whole, separated by a four-entry queue.
// when rsp stalls, the cordic pipeline holds, the queue fills and then the
// front holds and req.ready drops; no transaction is lost or repeated.
// reset (rst, synchronous) clears every valid bit and the queue pointers;
// there is no clearing pass and the block accepts from the first cycle after.
// ---------------------------------------------------------------------------
module polar_rect_converter_core (
  input  logic clk,
  input  logic rst,
  prc_in_if.sink    req,
  prc_out_if.source rsp
);

  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  prc_pkg::queue_t push_data;
  prc_pkg::queue_t head;

  prc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  prc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  prc_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule
